FILE: rtl/running_stats_accumulator_macros.svh
// Assertion macros for the running statistics accumulator.
// Included by modules that check their own control logic; expects clk_i and rst_ni in scope.
`ifndef RUNNING_STATS_ACCUMULATOR_MACROS_SVH
`define RUNNING_STATS_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while in reset
`define RSACC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, off while in reset
`define RSACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSACC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RSACC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/rsacc_pkg.sv
// Shared types and constants of the running statistics accumulator.
// No dependencies; used by the channel interfaces and the top level.
package rsacc_pkg;

  // default configuration
  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int ACT_W     = 1;
  localparam int VAL_W     = 32;
  localparam int FACTOR_W  = 17;
  localparam int COUNT_W   = 48;
  localparam int SUM_W     = 64;
  localparam int SQ_W      = 63;
  localparam int STD_W     = 31;

  // merge factor is Q1.16
  localparam int FACTOR_BITS = 16;

  // request action codes
  localparam logic [ACT_W-1:0] ACT_ADD   = 1'b0;
  localparam logic [ACT_W-1:0] ACT_MERGE = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]           action;
    logic signed [VAL_W-1:0]    sample_value;
    logic [FACTOR_W-1:0]        merge_factor;
    logic [COUNT_W-1:0]         other_count;
    logic signed [SUM_W-1:0]    other_sum;
    logic [SQ_W-1:0]            other_sum_squares;
    logic signed [VAL_W-1:0]    other_min;
    logic signed [VAL_W-1:0]    other_max;
  } rsacc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         total_count;
    logic signed [SUM_W-1:0]    total_sum;
    logic signed [VAL_W-1:0]    mean_value;
    logic [STD_W-1:0]           std_deviation;
    logic signed [VAL_W-1:0]    min_value;
    logic signed [VAL_W-1:0]    max_value;
    logic                       saturated;
  } rsacc_out_t;

endpackage

FILE: rtl/rsacc_intf.sv
// Valid/ready channels of the running statistics accumulator.
// Depends on rsacc_pkg for the request and result payload types.
interface rsacc_in_if import rsacc_pkg::*; ();
  logic      valid;
  logic      ready;
  rsacc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsacc_out_if import rsacc_pkg::*; ();
  logic       valid;
  logic       ready;
  rsacc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/running_stats_accumulator.sv
// Running statistics accumulator: one request at a time; a merge request takes longer than a
// sample request, and either takes less when a quotient clamps or count is zero.
// The time is set by one bit-serial shift-add multiplier, a restoring divider (32 + 64 quotient
// bits) and a 32-step square root on one sequencer.
// The result register frees the sequencer: the next request is taken as soon as it is idle.
// Reset (rst_ni low, asynchronous) clears the record, the flag and all control state.
`include "running_stats_accumulator_macros.svh"

module running_stats_accumulator import rsacc_pkg::*; #(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsacc_in_if.sink    in_i,
  rsacc_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_APPLY, S_PREP_M, S_PREP_S, S_DIV, S_SQRT, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_SQR_SAMPLE, OP_SCALE_SUM, OP_SCALE_SQ, OP_SCALE_CNT, OP_SQR_MEAN
  } op_e;

  localparam int MUL_W    = 32;
  localparam int PROD_W   = SUM_W + MUL_W;
  localparam int MSH      = VAL_W - FRACTION_BITS;
  localparam int SSH      = SUM_W - 2 * FRACTION_BITS;
  localparam logic [5:0] MUL_LAST  = 6'(MUL_W - 1);
  localparam logic [5:0] DIVM_LAST = 6'(VAL_W - 1);
  localparam logic [5:0] DIVS_LAST = 6'(SUM_W - 1);
  localparam logic [5:0] SQRT_LAST = 6'(SUM_W / 2 - 1);
  localparam logic [COUNT_W-1:0] CNT_ONE   = COUNT_W'(64'd1 << FRACTION_BITS);
  localparam logic [SUM_W-1:0]   S64_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   S64_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]   STD_MAX64 = SUM_W'({STD_W{1'b1}});
  localparam logic [VAL_W-1:0]   MEAN_POS  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]   MEAN_NEG  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]   SQRT_BIT0 = SUM_W'(64'd1 << (SUM_W - 2));

  // control
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [5:0] cnt_q, cnt_d;
  logic   div_s_q, div_s_d;
  logic   out_valid_q, out_valid_d;

  // statistics record
  logic [COUNT_W-1:0]             count_q, count_d;
  logic [SUM_W-1:0]               sum_q, sum_d;
  logic [SQ_W-1:0]                sq_q, sq_d;
  logic signed [SAMPLE_WIDTH-1:0] min_q, min_d;
  logic signed [SAMPLE_WIDTH-1:0] max_q, max_d;
  logic                           ovf_q, ovf_d;

  // latched request
  logic signed [SAMPLE_WIDTH-1:0] sample_q, sample_d;
  logic [FACTOR_W-1:0]            f_q, f_d;
  logic [COUNT_W-1:0]             ocnt_q, ocnt_d;
  logic [SQ_W-1:0]                osq_q, osq_d;
  logic                           osum_neg_q, osum_neg_d;

  // serial multiplier, divider and root
  logic [SUM_W-1:0] mc_q, mc_d;
  logic [MUL_W-1:0] mp_q, mp_d;
  logic [SUM_W-1:0] ph_q, ph_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] dz_q, dz_d;
  logic [VAL_W-1:0] m_q, m_d;
  logic [SUM_W-1:0] s_q, s_d;
  logic [SUM_W-1:0] sv_q, sv_d;
  logic [SUM_W-1:0] sres_q, sres_d;
  logic [SUM_W-1:0] sbit_q, sbit_d;
  logic [VAL_W-1:0] mean_q, mean_d;
  logic [STD_W-1:0] std_q, std_d;
  rsacc_out_t       out_q, out_d;

  // combinational helpers
  logic                           in_acc;
  logic                           empty;
  logic signed [SAMPLE_WIDTH-1:0] smp, lo_c, hi_c;
  logic [SUM_W-1:0]               smp_ext, smp_mag, osum_mag;
  logic [SUM_W:0]                 mul_sum;
  logic [PROD_W-1:0]              prod, prod_sh;
  logic                           scale_sat;
  logic [SUM_W-1:0]               scale_val;
  logic                           ssum_clip;
  logic [SUM_W-1:0]               ssum;
  logic [SUM_W-1:0]               sum_b, sq_b, cnt_b;
  logic [SUM_W:0]                 s65, q65, c65;
  logic                           ovf_sum, ovf_sq, ovf_cnt;
  logic [SUM_W-1:0]               sum_new;
  logic [SQ_W-1:0]                sq_new;
  logic [COUNT_W-1:0]             cnt_new;
  logic [SUM_W-1:0]               count64, sum_mag, sum_sh, sq64, sq_sh;
  logic [SUM_W-1:0]               rinit_m, rinit_s, zload_m, zload_s;
  logic [COUNT_W:0]               div_rt, div_diff;
  logic                           div_ge;
  logic [SUM_W-1:0]               dz_step;
  logic [SUM_W-1:0]               sq_mm, var_v;
  logic [SUM_W-1:0]               rt_t, sv_nx, sres_nx;
  logic                           rt_take;
  logic [STD_W-1:0]               std_fin;
  logic [VAL_W-1:0]               mm_clip, mean_fin;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // request decode: sample sign extension, magnitudes, min/max candidates
  assign empty    = (count_q == '0);
  assign smp      = in_i.data.sample_value[SAMPLE_WIDTH-1:0];
  assign smp_ext  = SUM_W'(smp);
  assign smp_mag  = smp_ext[SUM_W-1] ? (~smp_ext + 64'd1) : smp_ext;
  assign osum_mag = in_i.data.other_sum[SUM_W-1] ? (~in_i.data.other_sum + 64'd1)
                                                 : in_i.data.other_sum;
  assign lo_c = (in_i.data.action == ACT_MERGE) ? in_i.data.other_min[SAMPLE_WIDTH-1:0] : smp;
  assign hi_c = (in_i.data.action == ACT_MERGE) ? in_i.data.other_max[SAMPLE_WIDTH-1:0] : smp;

  // one shift-add step: add multiplicand on the low multiplier bit, shift right
  assign mul_sum = {1'b0, ph_q} + (mp_q[0] ? {1'b0, mc_q} : '0);
  assign prod    = {ph_q, mp_q};
  assign prod_sh = prod >> FRACTION_BITS;

  // scaled product: drop the factor's fraction, clamp to all ones
  assign scale_sat = |prod[PROD_W-1:FACTOR_BITS+SUM_W];
  assign scale_val = scale_sat ? '1 : prod[FACTOR_BITS +: SUM_W];
  assign ssum_clip = osum_neg_q ? (scale_val > S64_MIN) : scale_val[SUM_W-1];
  assign ssum      = osum_neg_q ? (ssum_clip ? S64_MIN : (~scale_val + 64'd1))
                                : (ssum_clip ? S64_MAX : scale_val);

  // accumulator adders with saturation
  assign sum_b = (op_q == OP_SQR_SAMPLE) ? SUM_W'(sample_q) : ssum;
  assign sq_b  = (op_q == OP_SQR_SAMPLE) ? SUM_W'(prod_sh[SQ_W-1:0]) : scale_val;
  assign cnt_b = (op_q == OP_SQR_SAMPLE) ? SUM_W'(CNT_ONE) : scale_val;

  assign s65     = {sum_q[SUM_W-1], sum_q} + {sum_b[SUM_W-1], sum_b};
  assign ovf_sum = s65[SUM_W] ^ s65[SUM_W-1];
  assign sum_new = ovf_sum ? (s65[SUM_W] ? S64_MIN : S64_MAX) : s65[SUM_W-1:0];

  assign q65    = {2'b00, sq_q} + {1'b0, sq_b};
  assign ovf_sq = q65[SUM_W] | q65[SUM_W-1];
  assign sq_new = ovf_sq ? '1 : q65[SQ_W-1:0];

  assign c65     = {{(SUM_W-COUNT_W+1){1'b0}}, count_q} + {1'b0, cnt_b};
  assign ovf_cnt = |c65[SUM_W:COUNT_W];
  assign cnt_new = ovf_cnt ? '1 : c65[COUNT_W-1:0];

  // divider set-up: high part is the starting remainder, low part is shifted in
  assign count64 = SUM_W'(count_q);
  assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + 64'd1) : sum_q;
  assign sum_sh  = sum_mag << FRACTION_BITS;
  assign rinit_m = sum_mag >> MSH;
  assign zload_m = {sum_sh[VAL_W-1:0], {(SUM_W-VAL_W){1'b0}}};
  assign sq64    = {1'b0, sq_q};
  assign sq_sh   = sq64 << (2 * FRACTION_BITS);
  assign rinit_s = sq64 >> SSH;
  assign zload_s = sq_sh;

  // one restoring division step
  assign div_rt   = {rem_q, dz_q[SUM_W-1]};
  assign div_ge   = (div_rt >= {1'b0, count_q});
  assign div_diff = div_rt - {1'b0, count_q};
  assign dz_step  = {dz_q[SUM_W-2:0], div_ge};

  // variance with the negative case repaired to zero
  assign sq_mm = prod[SUM_W-1:0];
  assign var_v = (s_q > sq_mm) ? (s_q - sq_mm) : '0;

  // one square root step, two radicand bits per cycle
  assign rt_t    = sres_q + sbit_q;
  assign rt_take = (sv_q >= rt_t);
  assign sv_nx   = rt_take ? (sv_q - rt_t) : sv_q;
  assign sres_nx = rt_take ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
  assign std_fin = (sres_nx > STD_MAX64) ? '1 : sres_nx[STD_W-1:0];

  // signed, clamped mean
  assign mm_clip  = (m_q > MEAN_NEG) ? MEAN_NEG : m_q;
  assign mean_fin = sum_q[SUM_W-1] ? (~mm_clip + 32'd1)
                                   : ((m_q > MEAN_POS) ? MEAN_POS : m_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    div_s_d     = div_s_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    min_d       = min_q;
    max_d       = max_q;
    ovf_d       = ovf_q;
    sample_d    = sample_q;
    f_d         = f_q;
    ocnt_d      = ocnt_q;
    osq_d       = osq_q;
    osum_neg_d  = osum_neg_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    ph_d        = ph_q;
    rem_d       = rem_q;
    dz_d        = dz_q;
    m_d         = m_q;
    s_d         = s_q;
    sv_d        = sv_q;
    sres_d      = sres_q;
    sbit_d      = sbit_q;
    mean_d      = mean_q;
    std_d       = std_q;
    out_d       = out_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sample_d   = smp;
          f_d        = in_i.data.merge_factor;
          ocnt_d     = in_i.data.other_count;
          osq_d      = in_i.data.other_sum_squares;
          osum_neg_d = in_i.data.other_sum[SUM_W-1];
          // an empty record takes the new extremes outright
          if (empty || (min_q > lo_c)) begin
            min_d = lo_c;
          end
          if (empty || (max_q < hi_c)) begin
            max_d = hi_c;
          end
          ph_d    = '0;
          cnt_d   = MUL_LAST;
          state_d = S_MUL;
          if (in_i.data.action == ACT_MERGE) begin
            mc_d = osum_mag;
            mp_d = MUL_W'(in_i.data.merge_factor);
            op_d = OP_SCALE_SUM;
          end else begin
            mc_d = smp_mag;
            mp_d = smp_mag[MUL_W-1:0];
            op_d = OP_SQR_SAMPLE;
          end
        end
      end

      S_MUL: begin
        ph_d  = mul_sum[SUM_W:1];
        mp_d  = {mul_sum[0], mp_q[MUL_W-1:1]};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        case (op_q)
          OP_SQR_SAMPLE: begin
            sum_d   = sum_new;
            sq_d    = sq_new;
            count_d = cnt_new;
            ovf_d   = ovf_q | ovf_sum | ovf_sq | ovf_cnt;
            state_d = S_PREP_M;
          end
          OP_SCALE_SUM: begin
            sum_d   = sum_new;
            ovf_d   = ovf_q | scale_sat | ssum_clip | ovf_sum;
            mc_d    = SUM_W'(osq_q);
            mp_d    = MUL_W'(f_q);
            ph_d    = '0;
            cnt_d   = MUL_LAST;
            op_d    = OP_SCALE_SQ;
            state_d = S_MUL;
          end
          OP_SCALE_SQ: begin
            sq_d    = sq_new;
            ovf_d   = ovf_q | scale_sat | ovf_sq;
            mc_d    = SUM_W'(ocnt_q);
            mp_d    = MUL_W'(f_q);
            ph_d    = '0;
            cnt_d   = MUL_LAST;
            op_d    = OP_SCALE_CNT;
            state_d = S_MUL;
          end
          OP_SCALE_CNT: begin
            count_d = cnt_new;
            ovf_d   = ovf_q | scale_sat | ovf_cnt;
            state_d = S_PREP_M;
          end
          OP_SQR_MEAN: begin
            sv_d    = var_v;
            sres_d  = '0;
            sbit_d  = SQRT_BIT0;
            cnt_d   = SQRT_LAST;
            state_d = S_SQRT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // mean magnitude: |sum| * 2^F / count, clamped to 32 bits; an empty record gives zero mean and deviation
      S_PREP_M: begin
        if (count_q == '0) begin
          mean_d  = '0;
          std_d   = '0;
          state_d = S_OUT;
        end else if (rinit_m >= count64) begin
          m_d     = '1;
          state_d = S_PREP_S;
        end else begin
          rem_d   = rinit_m[COUNT_W-1:0];
          dz_d    = zload_m;
          cnt_d   = DIVM_LAST;
          div_s_d = 1'b0;
          state_d = S_DIV;
        end
      end

      // mean square: squares * 2^2F / count, clamped to 64 bits
      S_PREP_S: begin
        if (rinit_s >= count64) begin
          s_d     = '1;
          mc_d    = SUM_W'(m_q);
          mp_d    = m_q;
          ph_d    = '0;
          cnt_d   = MUL_LAST;
          op_d    = OP_SQR_MEAN;
          state_d = S_MUL;
        end else begin
          rem_d   = rinit_s[COUNT_W-1:0];
          dz_d    = zload_s;
          cnt_d   = DIVS_LAST;
          div_s_d = 1'b1;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        rem_d = div_ge ? div_diff[COUNT_W-1:0] : div_rt[COUNT_W-1:0];
        dz_d  = dz_step;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          if (!div_s_q) begin
            m_d     = dz_step[VAL_W-1:0];
            state_d = S_PREP_S;
          end else begin
            s_d     = dz_step;
            mc_d    = SUM_W'(m_q);
            mp_d    = m_q;
            ph_d    = '0;
            cnt_d   = MUL_LAST;
            op_d    = OP_SQR_MEAN;
            state_d = S_MUL;
          end
        end
      end

      S_SQRT: begin
        sv_d   = sv_nx;
        sres_d = sres_nx;
        sbit_d = sbit_q >> 2;
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          std_d   = std_fin;
          mean_d  = mean_fin;
          state_d = S_OUT;
        end
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.total_count   = count_q;
          out_d.total_sum     = sum_q;
          out_d.mean_value    = mean_q;
          out_d.std_deviation = std_q;
          out_d.min_value     = VAL_W'(min_q);
          out_d.max_value     = VAL_W'(max_q);
          out_d.saturated     = ovf_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state, record and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_SQR_SAMPLE;
      cnt_q       <= '0;
      div_s_q     <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      min_q       <= '0;
      max_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      div_s_q     <= div_s_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      min_q       <= min_d;
      max_q       <= max_d;
      ovf_q       <= ovf_d;
    end
  end

  // datapath and result payload, no reset
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    f_q        <= f_d;
    ocnt_q     <= ocnt_d;
    osq_q      <= osq_d;
    osum_neg_q <= osum_neg_d;
    mc_q       <= mc_d;
    mp_q       <= mp_d;
    ph_q       <= ph_d;
    rem_q      <= rem_d;
    dz_q       <= dz_d;
    m_q        <= m_d;
    s_q        <= s_d;
    sv_q       <= sv_d;
    sres_q     <= sres_d;
    sbit_q     <= sbit_d;
    mean_q     <= mean_d;
    std_q      <= std_d;
    out_q      <= out_d;
  end

  // checks
  `RSACC_ASSERT_NEXT(a_one_request, in_i.valid && in_i.ready, !in_i.ready, "second request taken while busy")
  `RSACC_ASSERT_NEXT(a_sat_sticky, ovf_q, ovf_q, "saturation flag cleared without reset")
  `RSACC_ASSERT_IMPL(a_div_rem, state_q == S_DIV, rem_q < count_q, "divider remainder not below count")
  `RSACC_ASSERT_IMPL(a_zero_count, out_o.valid && (out_o.data.total_count == '0), (out_o.data.mean_value == '0) && (out_o.data.std_deviation == '0), "nonzero mean or deviation with empty record")

endmodule
